### hw/rtl/mlcc_pkg.sv
package mlcc_pkg;

  // Request kinds carried by an input word.
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_STORE = 3'd1;
  localparam logic [2:0] KIND_GETS  = 3'd2;
  localparam logic [2:0] KIND_GETM  = 3'd3;
  localparam logic [2:0] KIND_DATA  = 3'd4;

  // Bus request codes.
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_GETS = 2'd1;
  localparam logic [1:0] REQ_GETM = 2'd2;

  // Fault codes.
  localparam logic [1:0] FAULT_OK         = 2'd0;
  localparam logic [1:0] FAULT_PENDING    = 2'd1;
  localparam logic [1:0] FAULT_UNEXPECTED = 2'd2;

  // Encoded line state as reported on the result word.
  localparam logic [2:0] CODE_I  = 3'd0;
  localparam logic [2:0] CODE_IS = 3'd1;
  localparam logic [2:0] CODE_IM = 3'd2;
  localparam logic [2:0] CODE_S  = 3'd3;
  localparam logic [2:0] CODE_SM = 3'd4;
  localparam logic [2:0] CODE_O  = 3'd5;
  localparam logic [2:0] CODE_M  = 3'd6;

  // Line state, one-hot.
  typedef enum logic [6:0] {
    ST_I  = 7'b0000001,
    ST_IS = 7'b0000010,
    ST_IM = 7'b0000100,
    ST_S  = 7'b0001000,
    ST_SM = 7'b0010000,
    ST_O  = 7'b0100000,
    ST_M  = 7'b1000000
  } line_state_t;

  // Control part of one result word.
  typedef struct packed {
    logic [1:0] bus_request;
    logic       proc_data;
    logic       bus_data;
    logic       assert_shared;
    logic       miss;
    logic [1:0] fault;
  } step_result_t;

  // Map the one-hot state to its reported code.
  function automatic logic [2:0] state_code(line_state_t s);
    logic [2:0] code;
    case (s)
      ST_I:    code = CODE_I;
      ST_IS:   code = CODE_IS;
      ST_IM:   code = CODE_IM;
      ST_S:    code = CODE_S;
      ST_SM:   code = CODE_SM;
      ST_O:    code = CODE_O;
      ST_M:    code = CODE_M;
      default: code = CODE_I;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/mlcc_step.sv
module mlcc_step #(
  parameter int NODE_BITS = 4
) (
  input  logic [2:0]            kind,
  input  logic [NODE_BITS-1:0]  source_node,
  input  logic                  shared_seen,
  input  mlcc_pkg::line_state_t line_state,
  input  logic                  owner_valid,
  input  logic [NODE_BITS-1:0]  owner_node,
  output mlcc_pkg::line_state_t line_state_next,
  output logic                  owner_valid_next,
  output logic [NODE_BITS-1:0]  owner_node_next,
  output mlcc_pkg::step_result_t result
);

  logic is_proc;
  logic is_snoop_req;
  logic is_legal;
  logic pending;
  logic supply_in_sm;

  assign is_proc      = (kind == mlcc_pkg::KIND_LOAD) || (kind == mlcc_pkg::KIND_STORE);
  assign is_snoop_req = (kind == mlcc_pkg::KIND_GETS) || (kind == mlcc_pkg::KIND_GETM);
  assign is_legal     = (kind <= mlcc_pkg::KIND_DATA);
  assign pending      = (line_state == mlcc_pkg::ST_IS) || (line_state == mlcc_pkg::ST_IM) ||
                        (line_state == mlcc_pkg::ST_SM);
  assign supply_in_sm = owner_valid && !shared_seen;

  // Transition table for one word; faults hold all state.
  always_comb begin
    result           = '0;
    line_state_next  = line_state;
    owner_valid_next = owner_valid;
    owner_node_next  = owner_node;
    if (!is_legal) begin
      result.fault = mlcc_pkg::FAULT_UNEXPECTED;
    end else if (is_proc && pending) begin
      result.fault = mlcc_pkg::FAULT_PENDING;
    end else begin
      case (line_state)
        mlcc_pkg::ST_I: begin
          if (kind == mlcc_pkg::KIND_LOAD) begin
            result.bus_request = mlcc_pkg::REQ_GETS;
            result.miss        = 1'b1;
            line_state_next    = mlcc_pkg::ST_IS;
          end else if (kind == mlcc_pkg::KIND_STORE) begin
            result.bus_request = mlcc_pkg::REQ_GETM;
            result.miss        = 1'b1;
            line_state_next    = mlcc_pkg::ST_IM;
          end
        end
        mlcc_pkg::ST_IS: begin
          if (kind == mlcc_pkg::KIND_DATA) begin
            result.proc_data = 1'b1;
            line_state_next  = mlcc_pkg::ST_S;
          end
        end
        mlcc_pkg::ST_IM: begin
          if (kind == mlcc_pkg::KIND_DATA) begin
            result.proc_data = 1'b1;
            line_state_next  = mlcc_pkg::ST_M;
          end
        end
        mlcc_pkg::ST_S: begin
          if (kind == mlcc_pkg::KIND_LOAD) begin
            result.proc_data = 1'b1;
          end else if (kind == mlcc_pkg::KIND_STORE) begin
            result.bus_request = mlcc_pkg::REQ_GETM;
            result.miss        = 1'b1;
            line_state_next    = mlcc_pkg::ST_SM;
          end else if (kind == mlcc_pkg::KIND_GETM) begin
            line_state_next = mlcc_pkg::ST_I;
          end
        end
        mlcc_pkg::ST_SM: begin
          if (is_snoop_req) begin
            result.assert_shared = supply_in_sm;
            result.bus_data      = supply_in_sm;
            // A GETM from anyone but the recorded owner takes the line away.
            if ((kind == mlcc_pkg::KIND_GETM) &&
                (!owner_valid || (source_node != owner_node))) begin
              line_state_next  = mlcc_pkg::ST_IM;
              owner_valid_next = 1'b0;
              owner_node_next  = '0;
            end
          end else if (kind == mlcc_pkg::KIND_DATA) begin
            result.proc_data = 1'b1;
            line_state_next  = mlcc_pkg::ST_M;
            owner_valid_next = 1'b0;
            owner_node_next  = '0;
          end
        end
        mlcc_pkg::ST_O: begin
          if (kind == mlcc_pkg::KIND_LOAD) begin
            result.proc_data = 1'b1;
          end else if (kind == mlcc_pkg::KIND_STORE) begin
            result.bus_request = mlcc_pkg::REQ_GETM;
            result.miss        = 1'b1;
            line_state_next    = mlcc_pkg::ST_SM;
            owner_valid_next   = 1'b1;
            owner_node_next    = source_node;
          end else if (kind == mlcc_pkg::KIND_GETS) begin
            result.assert_shared = 1'b1;
            result.bus_data      = 1'b1;
          end else if (kind == mlcc_pkg::KIND_GETM) begin
            result.assert_shared = 1'b1;
            result.bus_data      = 1'b1;
            line_state_next      = mlcc_pkg::ST_I;
          end
        end
        mlcc_pkg::ST_M: begin
          if (is_proc) begin
            result.proc_data = 1'b1;
          end else if (kind == mlcc_pkg::KIND_GETS) begin
            result.assert_shared = 1'b1;
            result.bus_data      = 1'b1;
            line_state_next      = mlcc_pkg::ST_O;
          end else if (kind == mlcc_pkg::KIND_GETM) begin
            result.assert_shared = 1'b1;
            result.bus_data      = 1'b1;
            line_state_next      = mlcc_pkg::ST_I;
          end
        end
        default: begin
          result.fault = mlcc_pkg::FAULT_UNEXPECTED;
        end
      endcase
    end
  end

endmodule

### hw/rtl/mlcc_out_stage.sv
module mlcc_out_stage #(
  parameter int NODE_BITS = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  mlcc_pkg::step_result_t result,
  input  logic [ADDR_BITS-1:0]   address_in,
  input  logic [NODE_BITS-1:0]   dest_in,
  input  logic [2:0]             state_in,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             bus_request,
  output logic [ADDR_BITS-1:0]   address_out,
  output logic                   proc_data_valid,
  output logic                   bus_data_valid,
  output logic [NODE_BITS-1:0]   bus_data_dest,
  output logic                   assert_shared,
  output logic                   miss,
  output logic [1:0]             fault,
  output logic [2:0]             line_state_out
);

  // The result register is free when empty or when its word leaves now.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, held while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      bus_request     <= result.bus_request;
      address_out     <= address_in;
      proc_data_valid <= result.proc_data;
      bus_data_valid  <= result.bus_data;
      bus_data_dest   <= dest_in;
      assert_shared   <= result.assert_shared;
      miss            <= result.miss;
      fault           <= result.fault;
      line_state_out  <= state_in;
    end
  end

endmodule

### hw/rtl/mosi_line_coherence_controller_unit.sv
// MOSI snooping coherence controller for one cache line.
// Input channel (in_valid / in_stall) takes one request word per cycle while
// in_stall is low: a processor load or store, or a snooped GETS, GETM or DATA,
// with its address, source node and the current level of the bus shared line.
// Output channel (out_valid / out_stall) gives exactly one result word per
// request: bus request, processor data, bus data and its destination, shared
// line assertion, miss flag, fault code and the new line state.
// A request accepted into the input register is resolved against the line
// state in a single combinational step and loads into the result register
// as soon as that register is free. Throughput is one word per cycle while
// the receiver does not stall; the line state and owner register update in
// the same edge that loads the result register.
// When the receiver stalls, the result register holds its word and the input
// register may still take one more request; in_stall rises only when both
// are full. Reset (rst, synchronous) empties both registers and returns the
// line to I with no recorded owner.
module mosi_line_coherence_controller_unit #(
  parameter int NODE_BITS = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           kind,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [NODE_BITS-1:0] source_node,
  input  logic                 shared_seen,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           bus_request,
  output logic [ADDR_BITS-1:0] address_out,
  output logic                 proc_data_valid,
  output logic                 bus_data_valid,
  output logic [NODE_BITS-1:0] bus_data_dest,
  output logic                 assert_shared,
  output logic                 miss,
  output logic [1:0]           fault,
  output logic [2:0]           line_state_out
);

  logic                   req_valid;
  logic [2:0]             req_kind;
  logic [ADDR_BITS-1:0]   req_address;
  logic [NODE_BITS-1:0]   req_source;
  logic                   req_shared;

  mlcc_pkg::line_state_t  line_state;
  mlcc_pkg::line_state_t  line_state_next;
  logic                   owner_valid;
  logic                   owner_valid_next;
  logic [NODE_BITS-1:0]   owner_node;
  logic [NODE_BITS-1:0]   owner_node_next;

  mlcc_pkg::step_result_t result;
  logic                   out_ready;
  logic                   advance;
  logic [NODE_BITS-1:0]   dest;

  assign advance  = req_valid && out_ready;
  assign in_stall = req_valid && !out_ready;
  assign dest     = result.bus_data ? req_source : '0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind    <= kind;
      req_address <= address;
      req_source  <= source_node;
      req_shared  <= shared_seen;
    end
  end

  // Line state and recorded owner, updated as each word is resolved.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_state  <= mlcc_pkg::ST_I;
      owner_valid <= 1'b0;
      owner_node  <= '0;
    end else if (advance) begin
      line_state  <= line_state_next;
      owner_valid <= owner_valid_next;
      owner_node  <= owner_node_next;
    end
  end

  mlcc_step #(
    .NODE_BITS(NODE_BITS)
  ) u_step (
    .kind             (req_kind),
    .source_node      (req_source),
    .shared_seen      (req_shared),
    .line_state       (line_state),
    .owner_valid      (owner_valid),
    .owner_node       (owner_node),
    .line_state_next  (line_state_next),
    .owner_valid_next (owner_valid_next),
    .owner_node_next  (owner_node_next),
    .result           (result)
  );

  mlcc_out_stage #(
    .NODE_BITS(NODE_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) u_out_stage (
    .clk             (clk),
    .rst             (rst),
    .load            (advance),
    .result          (result),
    .address_in      (req_address),
    .dest_in         (dest),
    .state_in        (mlcc_pkg::state_code(line_state_next)),
    .ready           (out_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .bus_request     (bus_request),
    .address_out     (address_out),
    .proc_data_valid (proc_data_valid),
    .bus_data_valid  (bus_data_valid),
    .bus_data_dest   (bus_data_dest),
    .assert_shared   (assert_shared),
    .miss            (miss),
    .fault           (fault),
    .line_state_out  (line_state_out)
  );

  // A faulting word leaves the line state untouched.
  assert property (@(posedge clk) disable iff (rst)
    (advance && (result.fault != mlcc_pkg::FAULT_OK)) |=> (line_state == $past(line_state)))
    else $error("line state changed on a faulting word");

  // An owner is only recorded while the line waits in SM.
  assert property (@(posedge clk) disable iff (rst)
    owner_valid |-> (line_state == mlcc_pkg::ST_SM))
    else $error("owner recorded outside SM");

  // Supplying bus data always goes with asserting the shared line.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && bus_data_valid) |-> assert_shared)
    else $error("bus data supplied without shared line");

  // A miss always issues a bus request.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && miss) |-> (bus_request != mlcc_pkg::REQ_NONE))
    else $error("miss without bus request");

endmodule

### dv/mlcc_result_checker.sv
`timescale 1ns / 1ps

module mlcc_result_checker #(
  parameter int NODE_BITS = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           kind,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [NODE_BITS-1:0] source_node,
  input  logic                 shared_seen,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           bus_request,
  input  logic [ADDR_BITS-1:0] address_out,
  input  logic                 proc_data_valid,
  input  logic                 bus_data_valid,
  input  logic [NODE_BITS-1:0] bus_data_dest,
  input  logic                 assert_shared,
  input  logic                 miss,
  input  logic [1:0]           fault,
  input  logic [2:0]           line_state_out,
  output int                   fail_count,
  output int                   pending
);

  // One result word as the line controller should produce it.
  typedef struct packed {
    logic [1:0]           bus_req;
    logic [ADDR_BITS-1:0] addr;
    logic                 pdata;
    logic                 bdata;
    logic [NODE_BITS-1:0] dest;
    logic                 ashared;
    logic                 miss;
    logic [1:0]           fault;
    logic [2:0]           state;
  } line_result_t;

  // Shadow copy of the line state and the recorded owner.
  logic [2:0]           line_code;
  logic                 owner_ok;
  logic [NODE_BITS-1:0] owner_id;

  line_result_t due_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    line_code  = mlcc_pkg::CODE_I;
    owner_ok   = 1'b0;
    owner_id   = '0;
  end

  task automatic report_failure(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_failure($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Resolve one request word against the shadow line state.
  task automatic advance_line(input logic [2:0] k, input logic [ADDR_BITS-1:0] a,
                              input logic [NODE_BITS-1:0] s, input logic sh,
                              output line_result_t r);
    logic [2:0] nxt;
    logic       is_proc;
    r = '0;
    r.addr = a;
    nxt = line_code;
    is_proc = (k == mlcc_pkg::KIND_LOAD) || (k == mlcc_pkg::KIND_STORE);
    if (k > mlcc_pkg::KIND_DATA || line_code > mlcc_pkg::CODE_M) begin
      r.fault = mlcc_pkg::FAULT_UNEXPECTED;
    end else if (is_proc && (line_code == mlcc_pkg::CODE_IS ||
                             line_code == mlcc_pkg::CODE_IM ||
                             line_code == mlcc_pkg::CODE_SM)) begin
      r.fault = mlcc_pkg::FAULT_PENDING;
    end else begin
      case (line_code)
        mlcc_pkg::CODE_I: begin
          if (k == mlcc_pkg::KIND_LOAD) begin
            r.bus_req = mlcc_pkg::REQ_GETS;
            r.miss = 1'b1;
            nxt = mlcc_pkg::CODE_IS;
          end else if (k == mlcc_pkg::KIND_STORE) begin
            r.bus_req = mlcc_pkg::REQ_GETM;
            r.miss = 1'b1;
            nxt = mlcc_pkg::CODE_IM;
          end
        end
        mlcc_pkg::CODE_IS: begin
          if (k == mlcc_pkg::KIND_DATA) begin
            r.pdata = 1'b1;
            nxt = mlcc_pkg::CODE_S;
          end
        end
        mlcc_pkg::CODE_IM: begin
          if (k == mlcc_pkg::KIND_DATA) begin
            r.pdata = 1'b1;
            nxt = mlcc_pkg::CODE_M;
          end
        end
        mlcc_pkg::CODE_S: begin
          if (k == mlcc_pkg::KIND_LOAD) begin
            r.pdata = 1'b1;
          end else if (k == mlcc_pkg::KIND_STORE) begin
            r.bus_req = mlcc_pkg::REQ_GETM;
            r.miss = 1'b1;
            nxt = mlcc_pkg::CODE_SM;
          end else if (k == mlcc_pkg::KIND_GETM) begin
            nxt = mlcc_pkg::CODE_I;
          end
        end
        mlcc_pkg::CODE_SM: begin
          // Data is supplied only while an owner is recorded and nobody
          // else holds the shared line; a foreign GETM drops back to IM.
          if (k == mlcc_pkg::KIND_GETS || k == mlcc_pkg::KIND_GETM) begin
            if (owner_ok && !sh) begin
              r.ashared = 1'b1;
              r.bdata = 1'b1;
            end
            if (k == mlcc_pkg::KIND_GETM && (!owner_ok || s != owner_id)) begin
              nxt = mlcc_pkg::CODE_IM;
              owner_ok = 1'b0;
              owner_id = '0;
            end
          end else if (k == mlcc_pkg::KIND_DATA) begin
            owner_ok = 1'b0;
            owner_id = '0;
            r.pdata = 1'b1;
            nxt = mlcc_pkg::CODE_M;
          end
        end
        mlcc_pkg::CODE_O: begin
          if (k == mlcc_pkg::KIND_LOAD) begin
            r.pdata = 1'b1;
          end else if (k == mlcc_pkg::KIND_STORE) begin
            owner_ok = 1'b1;
            owner_id = s;
            r.bus_req = mlcc_pkg::REQ_GETM;
            r.miss = 1'b1;
            nxt = mlcc_pkg::CODE_SM;
          end else if (k == mlcc_pkg::KIND_GETS) begin
            r.ashared = 1'b1;
            r.bdata = 1'b1;
          end else if (k == mlcc_pkg::KIND_GETM) begin
            r.ashared = 1'b1;
            r.bdata = 1'b1;
            nxt = mlcc_pkg::CODE_I;
          end
        end
        default: begin
          if (is_proc) begin
            r.pdata = 1'b1;
          end else if (k == mlcc_pkg::KIND_GETS) begin
            r.ashared = 1'b1;
            r.bdata = 1'b1;
            nxt = mlcc_pkg::CODE_O;
          end else if (k == mlcc_pkg::KIND_GETM) begin
            r.ashared = 1'b1;
            r.bdata = 1'b1;
            nxt = mlcc_pkg::CODE_I;
          end
        end
      endcase
      line_code = nxt;
    end
    if (r.bdata) r.dest = s;
    r.state = line_code;
  endtask

  // Compare results leaving the block, then predict words entering it.
  always @(posedge clk) begin : watch_channels
    line_result_t want;
    line_result_t fresh;
    if (rst) begin
      line_code = mlcc_pkg::CODE_I;
      owner_ok  = 1'b0;
      owner_id  = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_failure("result word with no request outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("bus_request", 64'(bus_request), 64'(want.bus_req));
          check_field("address_out", 64'(address_out), 64'(want.addr));
          check_field("proc_data_valid", 64'(proc_data_valid), 64'(want.pdata));
          check_field("bus_data_valid", 64'(bus_data_valid), 64'(want.bdata));
          check_field("bus_data_dest", 64'(bus_data_dest), 64'(want.dest));
          check_field("assert_shared", 64'(assert_shared), 64'(want.ashared));
          check_field("miss", 64'(miss), 64'(want.miss));
          check_field("fault", 64'(fault), 64'(want.fault));
          check_field("line_state_out", 64'(line_state_out), 64'(want.state));
        end
      end
      if (in_valid && !in_stall) begin
        advance_line(kind, address, source_node, shared_seen, fresh);
        due_results.push_back(fresh);
      end
    end
    pending = due_results.size();
  end

endmodule

### dv/tb_mosi_line_coherence_controller_unit.sv
`timescale 1ns / 1ps

module tb_mosi_line_coherence_controller_unit;

  localparam int NODE_BITS   = 4;
  localparam int ADDR_BITS   = 32;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT = 600000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           kind;
  logic [ADDR_BITS-1:0] address;
  logic [NODE_BITS-1:0] source_node;
  logic                 shared_seen;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           bus_request;
  logic [ADDR_BITS-1:0] address_out;
  logic                 proc_data_valid;
  logic                 bus_data_valid;
  logic [NODE_BITS-1:0] bus_data_dest;
  logic                 assert_shared;
  logic                 miss;
  logic [1:0]           fault;
  logic [2:0]           line_state_out;
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  logic                 sender_steady = 1'b0;

  mosi_line_coherence_controller_unit #(
    .NODE_BITS(NODE_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) DUT (.*);

  mlcc_result_checker #(
    .NODE_BITS(NODE_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(40, 20);
  endfunction

  // Present one request word and hold it until the block takes it.
  task automatic send_word(input logic [2:0] k, input logic [ADDR_BITS-1:0] a,
                           input logic [NODE_BITS-1:0] s, input logic sh);
    int gap;
    in_valid    <= 1'b1;
    kind        <= k;
    address     <= a;
    source_node <= s;
    shared_seen <= sh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stalls: free runs and stall bursts of random length.
  initial begin : receiver_stalls
    int free_run;
    int hold;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      free_run = ($urandom_range(9) == 0) ? $urandom_range(150, 40)
                                          : $urandom_range(6, 1);
      repeat (free_run) @(posedge clk);
      out_stall <= 1'b1;
      hold = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(3, 1);
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    logic [ADDR_BITS-1:0] lo_addr;
    logic [ADDR_BITS-1:0] hi_addr;
    logic [2:0]           k;
    logic [ADDR_BITS-1:0] a;
    logic [NODE_BITS-1:0] s;
    logic [NODE_BITS-1:0] fav;
    int                   idx;
    int                   r;
    lo_addr     = '0;
    hi_addr     = '1;
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = mlcc_pkg::KIND_LOAD;
    address     = '0;
    source_node = '0;
    shared_seen = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every state and each corner of the protocol.
    send_word(mlcc_pkg::KIND_LOAD, lo_addr, 4'd0, 1'b0);    // I to IS, miss
    send_word(mlcc_pkg::KIND_STORE, hi_addr, 4'd15, 1'b1);  // pending transaction in IS
    send_word(mlcc_pkg::KIND_GETS, lo_addr, 4'd0, 1'b0);    // own GETS echoed back
    send_word(mlcc_pkg::KIND_DATA, hi_addr, 4'd3, 1'b1);    // IS to S
    send_word(mlcc_pkg::KIND_LOAD, lo_addr, 4'd0, 1'b0);    // hit in S
    send_word(mlcc_pkg::KIND_GETS, hi_addr, 4'd7, 1'b1);    // foreign GETS in S
    send_word(mlcc_pkg::KIND_STORE, lo_addr, 4'd2, 1'b0);   // S to SM with no owner
    send_word(mlcc_pkg::KIND_GETS, hi_addr, 4'd4, 1'b0);    // no owner, so no data
    send_word(mlcc_pkg::KIND_GETM, lo_addr, 4'd5, 1'b0);    // SM to IM
    send_word(mlcc_pkg::KIND_LOAD, hi_addr, 4'd1, 1'b1);    // pending transaction in IM
    send_word(mlcc_pkg::KIND_GETM, lo_addr, 4'd0, 1'b0);    // own GETM echoed back
    send_word(mlcc_pkg::KIND_DATA, hi_addr, 4'd8, 1'b0);    // IM to M
    send_word(3'd5, lo_addr, 4'd0, 1'b0);                   // illegal kind
    send_word(mlcc_pkg::KIND_GETS, hi_addr, 4'd15, 1'b1);   // M to O, supply data
    send_word(mlcc_pkg::KIND_LOAD, lo_addr, 4'd0, 1'b0);    // hit in O
    send_word(mlcc_pkg::KIND_GETS, hi_addr, 4'd6, 1'b1);    // O supplies data
    send_word(mlcc_pkg::KIND_STORE, lo_addr, 4'd9, 1'b0);   // O to SM, owner recorded
    send_word(mlcc_pkg::KIND_GETS, hi_addr, 4'd2, 1'b0);    // owner set, shared low: data
    send_word(mlcc_pkg::KIND_GETS, lo_addr, 4'd2, 1'b1);    // shared line high: no data
    send_word(mlcc_pkg::KIND_GETM, hi_addr, 4'd9, 1'b0);    // GETM from the owner stays
    send_word(mlcc_pkg::KIND_DATA, lo_addr, 4'd11, 1'b1);   // SM to M, owner cleared
    send_word(mlcc_pkg::KIND_STORE, hi_addr, 4'd13, 1'b0);  // hit in M
    send_word(mlcc_pkg::KIND_GETM, lo_addr, 4'd15, 1'b1);   // M to I
    send_word(3'd7, hi_addr, 4'd15, 1'b1);                  // illegal kind in I
    send_word(3'd6, lo_addr, 4'd10, 1'b0);                  // illegal kind in I
    send_word(mlcc_pkg::KIND_DATA, hi_addr, 4'd12, 1'b1);   // stray data in I

    // Random traffic; a favored node makes owner matches in SM common.
    fav = NODE_BITS'($urandom);
    for (idx = 0; idx < RANDOM_WORDS; idx++) begin
      if (idx % 100 == 0) sender_steady = ($urandom_range(3) == 0);
      if ($urandom_range(19) == 0) fav = NODE_BITS'($urandom);
      r = $urandom_range(99);
      if (r < 24) k = mlcc_pkg::KIND_LOAD;
      else if (r < 44) k = mlcc_pkg::KIND_STORE;
      else if (r < 58) k = mlcc_pkg::KIND_GETS;
      else if (r < 73) k = mlcc_pkg::KIND_GETM;
      else if (r < 93) k = mlcc_pkg::KIND_DATA;
      else k = 3'($urandom_range(7, 5));
      s = $urandom_range(1) ? fav : NODE_BITS'($urandom);
      r = $urandom_range(9);
      if (r == 0) a = lo_addr;
      else if (r == 1) a = hi_addr;
      else a = ADDR_BITS'($urandom);
      send_word(k, a, s, 1'($urandom_range(1)));
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
